/* rtl/core/abs_pkg.sv */
// abs_pkg: shared types and constants for the alternating-bit sender
// no dependencies
`timescale 1ns / 1ps

package abs_pkg;

  localparam int VALUE_W       = 16;
  localparam int CFG_W         = 16;
  localparam int DATA_WORD_W   = 19;
  localparam int SENT_ID_W     = 15;
  localparam int CFG_INDEX_W   = 1;

  localparam int TIMER_BITS_DEF   = 16;
  localparam int FILE_ID_BITS_DEF = 15;

  localparam logic [CFG_W-1:0] PREP_RESET    = 16'd10;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd20;

  localparam logic [CFG_INDEX_W-1:0] REG_PREP_TICKS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_DATA    = 2'd1,
    OP_ACK     = 2'd2,
    OP_REQUEST = 2'd3
  } opcode_t;

  typedef struct packed {
    logic                   data_valid;
    logic [DATA_WORD_W-1:0] data_word;
    logic [SENT_ID_W-1:0]   sent_file_id;
    logic                   ack_notice;
    logic                   request_more;
  } result_t;

endpackage

/* rtl/core/abs_cfg.sv */
// abs_cfg: delay registers, stored already clamped to the timer range
// depends on abs_pkg
`timescale 1ns / 1ps

module abs_cfg
  import abs_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic [TIMER_BITS-1:0]  prep_hold,
  output logic [TIMER_BITS-1:0]  timeout_hold
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // zero becomes one, too large saturates
  function automatic logic [TIMER_BITS-1:0] clamp_delay(input logic [CFG_W-1:0] d);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] lim;
    ext = CMP_W'(d);
    lim = CMP_W'({TIMER_BITS{1'b1}});
    if (ext == '0) begin
      ext = CMP_W'(1);
    end
    if (ext > lim) begin
      ext = lim;
    end
    return TIMER_BITS'(ext);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_hold    <= clamp_delay(PREP_RESET);
      timeout_hold <= clamp_delay(TIMEOUT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PREP_TICKS:    prep_hold    <= clamp_delay(cfg_data);
        REG_TIMEOUT_TICKS: timeout_hold <= clamp_delay(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/abs_engine.sv */
// abs_engine: sender flags, alternating bit, current file and retransmit timer
// depends on abs_pkg
`timescale 1ns / 1ps

module abs_engine
  import abs_pkg::*;
#(
  parameter int TIMER_BITS   = TIMER_BITS_DEF,
  parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  opcode_t                   op,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [TIMER_BITS-1:0]     prep_hold,
  input  logic [TIMER_BITS-1:0]     timeout_hold,
  output result_t                   res,
  output logic                      has_res
);

  logic [TIMER_BITS-1:0]   countdown, countdown_next;
  logic                    running, running_next;
  logic                    alt_bit, alt_bit_next;
  logic [FILE_ID_BITS-1:0] current_file, current_file_next;
  logic                    ack_pending, ack_pending_next;
  logic                    sending_flag, sending_flag_next;
  logic                    request_flag, request_flag_next;
  logic                    done_flag, done_flag_next;

  logic                    do_fire;
  logic [FILE_ID_BITS-1:0] file_in;
  logic [DATA_WORD_W-1:0]  file19;
  logic [DATA_WORD_W-1:0]  framed;

  assign file_in = FILE_ID_BITS'(value[VALUE_W-2:0]);
  assign file19  = DATA_WORD_W'(current_file);
  // file * 10 + bit, kept to the word width
  assign framed  = (file19 << 3) + (file19 << 1) + DATA_WORD_W'(alt_bit);

  always_comb begin
    countdown_next    = countdown;
    running_next      = running;
    alt_bit_next      = alt_bit;
    current_file_next = current_file;
    ack_pending_next  = ack_pending;
    sending_flag_next = sending_flag;
    request_flag_next = request_flag;
    done_flag_next    = done_flag;
    do_fire           = 1'b0;
    res               = '0;
    has_res           = 1'b0;

    case (op)
      OP_TICK: begin
        if (running) begin
          if (countdown > TIMER_BITS'(1)) begin
            countdown_next = countdown - TIMER_BITS'(1);
          end else begin
            countdown_next = '0;
            do_fire        = 1'b1;
          end
        end
      end
      OP_DATA: begin
        if (!value[VALUE_W-1] && (value != '0)) begin
          current_file_next = file_in;
          ack_pending_next  = 1'b0;
          sending_flag_next = 1'b1;
          request_flag_next = 1'b0;
          alt_bit_next      = ~alt_bit;
          countdown_next    = prep_hold;
          running_next      = 1'b1;
        end else if (value == '0) begin
          request_flag_next = 1'b1;
          do_fire           = 1'b1;
        end else begin
          request_flag_next = 1'b0;
          sending_flag_next = 1'b0;
          ack_pending_next  = 1'b0;
          done_flag_next    = 1'b1;
          do_fire           = 1'b1;
        end
      end
      OP_ACK: begin
        if (running && (value == VALUE_W'(alt_bit))) begin
          ack_pending_next  = 1'b1;
          sending_flag_next = 1'b0;
          do_fire           = 1'b1;
        end
      end
      OP_REQUEST: begin
        if (done_flag && !running) begin
          request_flag_next = 1'b1;
          done_flag_next    = 1'b0;
          do_fire           = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_fire) begin
      // report from the flags, then take the next phase
      if (sending_flag_next) begin
        res.data_valid   = 1'b1;
        res.data_word    = framed;
        res.sent_file_id = SENT_ID_W'(current_file);
        has_res          = 1'b1;
      end else begin
        res.ack_notice   = ack_pending_next;
        res.request_more = request_flag_next;
        has_res          = ack_pending_next | request_flag_next;
      end

      if (done_flag_next) begin
        running_next   = 1'b0;
        countdown_next = '0;
      end else if (ack_pending_next) begin
        ack_pending_next = 1'b0;
        running_next     = 1'b0;
        countdown_next   = '0;
      end else if (sending_flag_next) begin
        sending_flag_next = 1'b0;
        running_next      = 1'b1;
        countdown_next    = timeout_hold;
      end else if (request_flag_next) begin
        running_next   = 1'b1;
        countdown_next = timeout_hold;
      end else begin
        sending_flag_next = 1'b1;
        running_next      = 1'b1;
        countdown_next    = prep_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown    <= '0;
      running      <= 1'b0;
      alt_bit      <= 1'b0;
      current_file <= '0;
      ack_pending  <= 1'b0;
      sending_flag <= 1'b0;
      request_flag <= 1'b0;
      done_flag    <= 1'b1;
    end else if (step) begin
      countdown    <= countdown_next;
      running      <= running_next;
      alt_bit      <= alt_bit_next;
      current_file <= current_file_next;
      ack_pending  <= ack_pending_next;
      sending_flag <= sending_flag_next;
      request_flag <= request_flag_next;
      done_flag    <= done_flag_next;
    end
  end

endmodule

/* rtl/core/abs_out_reg.sv */
// abs_out_reg: result register on the output channel
// depends on abs_pkg
`timescale 1ns / 1ps

module abs_out_reg
  import abs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  result_t                res,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   data_valid,
  output logic [DATA_WORD_W-1:0] data_word,
  output logic [SENT_ID_W-1:0]   sent_file_id,
  output logic                   ack_notice,
  output logic                   request_more
);

  result_t held;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign data_valid   = held.data_valid;
  assign data_word    = held.data_word;
  assign sent_file_id = held.sent_file_id;
  assign ack_notice   = held.ack_notice;
  assign request_more = held.request_more;

endmodule

/* rtl/core/alternating_bit_sender.sv */
// alternating_bit_sender: top level, input register, engine and result register
// depends on abs_pkg, abs_cfg, abs_engine, abs_out_reg
`timescale 1ns / 1ps
//
//  channel   handshake              payload
//  input     in_valid / in_ready    opcode, value
//  output    out_valid / out_ready  data_valid, data_word, sent_file_id,
//                                   ack_notice, request_more
//  config    cfg_write              cfg_index, cfg_data
//
//  one request per cycle unless stalled; the request is registered, then its result, if any
//  the engine state updates in the cycle the registered request leaves the input stage
//  a held result stalls the input stage only while out_ready is low
//  synchronous reset clears timer, valids and flags but sets done; delays return to 10 and 20 ticks

module alternating_bit_sender
  import abs_pkg::*;
#(
  parameter int TIMER_BITS   = TIMER_BITS_DEF,
  parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      data_valid,
  output logic [DATA_WORD_W-1:0]    data_word,
  output logic [SENT_ID_W-1:0]      sent_file_id,
  output logic                      ack_notice,
  output logic                      request_more,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  logic                      s1_valid;
  opcode_t                   s1_op;
  logic signed [VALUE_W-1:0] s1_value;
  logic                      advance;
  logic                      out_free;
  logic [TIMER_BITS-1:0]     prep_hold;
  logic [TIMER_BITS-1:0]     timeout_hold;
  result_t                   res;
  logic                      has_res;

  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= opcode_t'(opcode);
      s1_value <= value;
    end
  end

  abs_cfg #(
    .TIMER_BITS(TIMER_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .prep_hold    (prep_hold),
    .timeout_hold (timeout_hold)
  );

  abs_engine #(
    .TIMER_BITS   (TIMER_BITS),
    .FILE_ID_BITS (FILE_ID_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .op           (s1_op),
    .value        (s1_value),
    .prep_hold    (prep_hold),
    .timeout_hold (timeout_hold),
    .res          (res),
    .has_res      (has_res)
  );

  abs_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && has_res),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_valid   (data_valid),
    .data_word    (data_word),
    .sent_file_id (sent_file_id),
    .ack_notice   (ack_notice),
    .request_more (request_more)
  );

endmodule

/* rtl/core/abs_checker.sv */
// abs_checker: port-level checks on the alternating-bit sender, bound to the top
// depends on abs_pkg
`timescale 1ns / 1ps

module abs_checker
  import abs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   data_valid,
  input logic [DATA_WORD_W-1:0] data_word,
  input logic [SENT_ID_W-1:0]   sent_file_id,
  input logic                   ack_notice,
  input logic                   request_more
);

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  // a file word never carries a notice or request
  a_data_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> !ack_notice && !request_more)
    else $error("file word mixed with notice or request");

  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_valid || ack_notice || request_more)
    else $error("empty result");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_word == '0 && sent_file_id == '0)
    else $error("file fields set without a file word");

endmodule

bind alternating_bit_sender abs_checker u_abs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_valid   (data_valid),
  .data_word    (data_word),
  .sent_file_id (sent_file_id),
  .ack_notice   (ack_notice),
  .request_more (request_more)
);
